// ===== sv/dhsc_pkg.sv =====
// shared types, constants and helpers of the dual hall sensor step counter
`timescale 1ns / 1ps

package dhsc_pkg;

  // fixed widths of the transaction fields
  localparam int CODE_BITS      = 3;
  localparam int POS_BITS       = 3;
  localparam int OUT_COUNT_BITS = 32;
  localparam int MAP_BITS       = 32;
  localparam int NIB_BITS       = 4;
  localparam int COUNT_BITS_DEFAULT = 32;

  // configuration port
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHEEL0_MAP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WHEEL1_MAP = 1'b1;

  // reset values per wheel
  localparam logic [MAP_BITS-1:0]  MAP0_RESET  = 32'hAB900C8D;
  localparam logic [MAP_BITS-1:0]  MAP1_RESET  = 32'h08A9CDB0;
  localparam logic [CODE_BITS-1:0] CODE0_RESET = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE1_RESET = 3'd6;

  // six-step commutation sequence
  localparam logic [POS_BITS:0]   SEQ_LEN  = 4'd6;
  localparam logic [POS_BITS-1:0] LAST_POS = 3'd5;

  typedef struct packed {
    logic [CODE_BITS-1:0] hall_a;
    logic [CODE_BITS-1:0] hall_b;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_COUNT_BITS-1:0] count_a;
    logic                             forward_a;
    logic                             valid_a;
    logic                             moved_a;
    logic [POS_BITS-1:0]              position_a;
    logic signed [OUT_COUNT_BITS-1:0] count_b;
    logic                             forward_b;
    logic                             valid_b;
    logic                             moved_b;
    logic [POS_BITS-1:0]              position_b;
  } out_item_t;

  // what one wheel lane reports for the current transaction
  typedef struct packed {
    logic signed [OUT_COUNT_BITS-1:0] count;
    logic                             forward;
    logic                             valid;
    logic                             moved;
    logic [POS_BITS-1:0]              position;
  } lane_res_t;

  // map nibble marks a usable position
  function automatic logic nib_ok(input logic [NIB_BITS-1:0] nib);
    return nib[NIB_BITS-1] && (nib[POS_BITS-1:0] <= LAST_POS);
  endfunction

  // forward distance from old to new position, modulo the sequence length
  function automatic logic [POS_BITS-1:0] step_dist(input logic [POS_BITS-1:0] new_pos,
                                                    input logic [POS_BITS-1:0] old_pos);
    logic [POS_BITS:0] sum;
    sum = {1'b0, new_pos} + SEQ_LEN - {1'b0, old_pos};
    if (sum >= SEQ_LEN) begin
      sum = sum - SEQ_LEN;
    end
    return sum[POS_BITS-1:0];
  endfunction

endpackage

// ===== sv/dhsc_lane.sv =====
// one wheel lane: code map, previous code, position, direction and step count
`timescale 1ns / 1ps

module dhsc_lane
  import dhsc_pkg::*;
#(
  parameter int                   COUNT_BITS = COUNT_BITS_DEFAULT,
  parameter logic [MAP_BITS-1:0]  MAP_RESET  = MAP0_RESET,
  parameter logic [CODE_BITS-1:0] CODE_RESET = CODE0_RESET
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  logic [CODE_BITS-1:0] hall,
  input  logic                 map_we,
  input  logic [MAP_BITS-1:0]  map_data,
  output lane_res_t            res
);

  logic [MAP_BITS-1:0]   code_map;
  logic [CODE_BITS-1:0]  prev_code, prev_code_next;
  logic [POS_BITS-1:0]   seq_pos, seq_pos_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  dir_flag, dir_flag_next;
  logic                  ok_flag, ok_flag_next;
  logic                  moved;

  logic [NIB_BITS-1:0]   old_nib, new_nib;
  logic                  pair_ok;
  logic [POS_BITS-1:0]   step_len;
  logic                  fwd_step, back_step;
  logic [1:0]            back_mag;

  // map lookups of the old and new code
  assign old_nib   = code_map[{prev_code, 2'b00} +: NIB_BITS];
  assign new_nib   = code_map[{hall, 2'b00} +: NIB_BITS];
  assign pair_ok   = nib_ok(old_nib) && nib_ok(new_nib);
  assign step_len  = step_dist(new_nib[POS_BITS-1:0], old_nib[POS_BITS-1:0]);
  assign fwd_step  = (step_len == 3'd1) || (step_len == 3'd2);
  assign back_step = (step_len == 3'd4) || (step_len == 3'd5);
  assign back_mag  = 2'(SEQ_LEN - {1'b0, step_len});

  // next state for this transaction
  always_comb begin
    prev_code_next = prev_code;
    seq_pos_next   = seq_pos;
    count_next     = count;
    dir_flag_next  = dir_flag;
    ok_flag_next   = ok_flag;
    moved          = 1'b0;
    if (hall != prev_code) begin
      prev_code_next = hall;
      priority if (!pair_ok) begin
        ok_flag_next = 1'b0;
      end else if (fwd_step) begin
        seq_pos_next  = new_nib[POS_BITS-1:0];
        dir_flag_next = 1'b1;
        ok_flag_next  = 1'b1;
        count_next    = count + COUNT_BITS'(step_len[1:0]);
        moved         = 1'b1;
      end else if (back_step) begin
        seq_pos_next  = new_nib[POS_BITS-1:0];
        dir_flag_next = 1'b0;
        ok_flag_next  = 1'b1;
        count_next    = count - COUNT_BITS'(back_mag);
        moved         = 1'b1;
      end else begin
        // half turn or two codes on one position
        seq_pos_next = new_nib[POS_BITS-1:0];
        ok_flag_next = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_map  <= MAP_RESET;
      prev_code <= CODE_RESET;
      seq_pos   <= '0;
      count     <= '0;
      dir_flag  <= 1'b0;
      ok_flag   <= 1'b0;
    end else begin
      if (map_we) begin
        code_map <= map_data;
      end
      if (step_en) begin
        prev_code <= prev_code_next;
        seq_pos   <= seq_pos_next;
        count     <= count_next;
        dir_flag  <= dir_flag_next;
        ok_flag   <= ok_flag_next;
      end
    end
  end

  // result of this transaction
  always_comb begin
    res.count    = OUT_COUNT_BITS'($signed(count_next));
    res.forward  = dir_flag_next;
    res.valid    = ok_flag_next;
    res.moved    = moved;
    res.position = seq_pos_next;
  end

`ifndef SYNTH
  a_moved_valid : assert property (@(posedge clk) disable iff (rst)
    res.moved |-> res.valid)
    else $error("step counted without a consistent sequence");
  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    seq_pos <= LAST_POS)
    else $error("sequence position out of range");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(count) && $stable(prev_code))
    else $error("lane state changed without a transaction");
`endif

endmodule

// ===== sv/dhsc_merge.sv =====
// merging stage: joins both lane results into one transaction, output register and skid
`timescale 1ns / 1ps

module dhsc_merge
  import dhsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  lane_res_t res_a,
  input  lane_res_t res_b,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t merged;
  out_item_t skid_data;
  logic      skid_full;
  logic      accept;
  logic      out_take;

  // combine the two lanes
  always_comb begin
    merged.count_a    = res_a.count;
    merged.forward_a  = res_a.forward;
    merged.valid_a    = res_a.valid;
    merged.moved_a    = res_a.moved;
    merged.position_a = res_a.position;
    merged.count_b    = res_b.count;
    merged.forward_b  = res_b.forward;
    merged.valid_b    = res_b.valid;
    merged.moved_b    = res_b.moved;
    merged.position_b = res_b.position;
  end

  assign in_stall = skid_full;
  assign accept   = in_valid && !skid_full;
  assign out_take = out_valid && !out_stall;

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        out_data  <= skid_data;
        skid_full <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_take) begin
        out_data  <= merged;
        out_valid <= 1'b1;
      end else begin
        skid_data <= merged;
        skid_full <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid holds a transaction while the output is empty");
  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    accept && out_valid && out_stall |=> skid_full)
    else $error("transaction lost while the output was stalled");
`endif

endmodule

// ===== sv/dual_hall_sensor_step_counter_unit.sv =====
// top level of the dual hall sensor step counter
`timescale 1ns / 1ps

// Decodes the hall codes of two wheels into six-step positions and step counts.
// Input channel in_valid / in_stall / in_data carries hall_a and hall_b; every
// accepted transaction yields exactly one result on out_valid / out_stall /
// out_data with count, direction, valid, moved and position of both wheels.
// Each wheel has its own lane; the merging stage joins them into one result.
// Results are registered in the output register, or in the skid entry if held.
// Throughput: one transaction per cycle unless in_stall is high; per cycle the
// path is one map lookup, a modulo-six distance and one COUNT_BITS add per lane.
// Stalling: the output register has one skid entry behind it; in_stall rises
// only once both are full, and a stalled result holds until taken.
// Configuration: cfg_we writes cfg_data into the code map chosen by cfg_index
// (0 wheel 0, 1 wheel 1); write only while no transaction is in flight.
// Reset (rst, synchronous): maps return to their defaults, previous codes to
// 1 and 6, counts, positions and flags to zero, and the output empties.
module dual_hall_sensor_step_counter_unit
  import dhsc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic      accept;
  logic      map0_we, map1_we;
  lane_res_t res_a, res_b;

  assign accept  = in_valid && !in_stall;
  assign map0_we = cfg_we && (cfg_index == REG_WHEEL0_MAP);
  assign map1_we = cfg_we && (cfg_index == REG_WHEEL1_MAP);

  // wheel 0 lane
  dhsc_lane #(
    .COUNT_BITS (COUNT_BITS),
    .MAP_RESET  (MAP0_RESET),
    .CODE_RESET (CODE0_RESET)
  ) u_lane_a (
    .clk      (clk),
    .rst      (rst),
    .step_en  (accept),
    .hall     (in_data.hall_a),
    .map_we   (map0_we),
    .map_data (MAP_BITS'(cfg_data)),
    .res      (res_a)
  );

  // wheel 1 lane
  dhsc_lane #(
    .COUNT_BITS (COUNT_BITS),
    .MAP_RESET  (MAP1_RESET),
    .CODE_RESET (CODE1_RESET)
  ) u_lane_b (
    .clk      (clk),
    .rst      (rst),
    .step_en  (accept),
    .hall     (in_data.hall_b),
    .map_we   (map1_we),
    .map_data (MAP_BITS'(cfg_data)),
    .res      (res_b)
  );

  // merge and output buffering
  dhsc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_a     (res_a),
    .res_b     (res_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_top.sv =====
// testbench of the dual hall sensor step counter: directed table, then random hall sequences
`timescale 1ns / 1ps

module tb_top;
  import dhsc_pkg::*;

  localparam int LANE_W     = $bits(lane_res_t);
  localparam int WATCH_IDLE = 1000;
  localparam int PHASE_LEN  = 215;

  typedef enum logic {ROW_STEP, ROW_WRITE} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t                kind;
    logic [CODE_BITS-1:0]     hall_a;
    logic [CODE_BITS-1:0]     hall_b;
    logic                     typed;
    out_item_t                report;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } stim_row_t;

  // tracked state of one wheel
  typedef struct packed {
    logic [CODE_BITS-1:0]      code;
    logic [POS_BITS-1:0]       pos;
    logic [OUT_COUNT_BITS-1:0] steps;
    logic                      fwd;
    logic                      ok;
  } hall_wheel_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_WHEEL0_MAP;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  logic [MAP_BITS-1:0] map_a, map_b;
  hall_wheel_t         wheel_a, wheel_b;
  out_item_t           pending_reports [$];
  stim_row_t           stim_tab [$];
  logic                cur_typed = 1'b0;
  out_item_t           cur_report = '0;
  logic                calm = 1'b0;
  int                  mismatches = 0;
  int                  idle_cycles = 0;

  dual_hall_sensor_step_counter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // map nibble holds a valid bit and a position inside the sequence
  function automatic logic usable(input logic [NIB_BITS-1:0] nib);
    return nib[3] && (nib[2:0] < 3'd6);
  endfunction

  function automatic lane_res_t wheel_report(input int count, input logic fwd,
                                             input logic ok, input logic moved,
                                             input logic [POS_BITS-1:0] pos);
    lane_res_t r;
    r.count    = count;
    r.forward  = fwd;
    r.valid    = ok;
    r.moved    = moved;
    r.position = pos;
    return r;
  endfunction

  // one wheel: look up old and new codes, count steps of one or two either way
  task automatic advance_wheel(inout hall_wheel_t ws, input logic [MAP_BITS-1:0] map,
                               input logic [CODE_BITS-1:0] code, output lane_res_t res);
    logic [NIB_BITS-1:0] old_nib, new_nib;
    int                  step_len;
    logic                stepped;
    stepped = 1'b0;
    if (code != ws.code) begin
      old_nib = map[ws.code*4 +: 4];
      new_nib = map[code*4 +: 4];
      ws.code = code;
      if (!usable(old_nib) || !usable(new_nib)) begin
        ws.ok = 1'b0;
      end else begin
        step_len = (int'(new_nib[2:0]) - int'(old_nib[2:0]) + 6) % 6;
        ws.pos = new_nib[2:0];
        if (step_len == 1 || step_len == 2) begin
          ws.fwd   = 1'b1;
          ws.ok    = 1'b1;
          ws.steps = ws.steps + step_len;
          stepped  = 1'b1;
        end else if (step_len == 4 || step_len == 5) begin
          ws.fwd   = 1'b0;
          ws.ok    = 1'b1;
          ws.steps = ws.steps - (6 - step_len);
          stepped  = 1'b1;
        end else begin
          // half turn, or two codes on one position
          ws.ok = 1'b0;
        end
      end
    end
    res = wheel_report(ws.steps, ws.fwd, ws.ok, stepped, ws.pos);
  endtask

  // field by field comparison of both wheels
  task automatic check_report(input out_item_t want, input out_item_t got);
    lane_res_t e, g;
    string     tag;
    for (int w = 0; w < 2; w++) begin
      e   = (w == 0) ? want[2*LANE_W-1:LANE_W] : want[LANE_W-1:0];
      g   = (w == 0) ? got[2*LANE_W-1:LANE_W] : got[LANE_W-1:0];
      tag = (w == 0) ? "a" : "b";
      if (e.count !== g.count) begin
        $display("%0t: count_%s expected %0d got %0d", $time, tag, e.count, g.count);
        mismatches++;
      end
      if (e.forward !== g.forward) begin
        $display("%0t: forward_%s expected %0b got %0b", $time, tag, e.forward, g.forward);
        mismatches++;
      end
      if (e.valid !== g.valid) begin
        $display("%0t: valid_%s expected %0b got %0b", $time, tag, e.valid, g.valid);
        mismatches++;
      end
      if (e.moved !== g.moved) begin
        $display("%0t: moved_%s expected %0b got %0b", $time, tag, e.moved, g.moved);
        mismatches++;
      end
      if (e.position !== g.position) begin
        $display("%0t: position_%s expected %0d got %0d", $time, tag, e.position,
                 g.position);
        mismatches++;
      end
    end
  endtask

  // predictor and result check, all on the rising edge
  always @(posedge clk) begin
    lane_res_t ra, rb;
    if (rst) begin
      map_a   = MAP0_RESET;
      map_b   = MAP1_RESET;
      wheel_a = '{code: CODE0_RESET, default: '0};
      wheel_b = '{code: CODE1_RESET, default: '0};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WHEEL0_MAP: map_a = cfg_data;
          REG_WHEEL1_MAP: map_b = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: result with no transaction pending, got %h", $time, out_data);
          mismatches++;
        end else begin
          check_report(pending_reports.pop_front(), out_data);
        end
      end
      if (in_valid && !in_stall) begin
        advance_wheel(wheel_a, map_a, in_data.hall_a, ra);
        advance_wheel(wheel_b, map_b, in_data.hall_b, rb);
        pending_reports.push_back(cur_typed ? cur_report : out_item_t'({ra, rb}));
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCH_IDLE) begin
      $display("FAIL dual_hall_sensor_step_counter_unit");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  function automatic stim_row_t step_row(input logic [CODE_BITS-1:0] a,
                                         input logic [CODE_BITS-1:0] b);
    stim_row_t r;
    r = '{kind: ROW_STEP, hall_a: a, hall_b: b, typed: 1'b0, report: '0,
          index: REG_WHEEL0_MAP, data: '0};
    return r;
  endfunction

  function automatic stim_row_t check_row(input logic [CODE_BITS-1:0] a,
                                          input logic [CODE_BITS-1:0] b,
                                          input lane_res_t la, input lane_res_t lb);
    stim_row_t r;
    r        = step_row(a, b);
    r.typed  = 1'b1;
    r.report = {la, lb};
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_BITS-1:0] idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    stim_row_t r;
    r       = step_row('0, '0);
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.data  = data;
    return r;
  endfunction

  // next hall code of one wheel: mostly a legal step from where it stands
  function automatic logic [CODE_BITS-1:0] pick_code(input logic [MAP_BITS-1:0] map,
                                                     input logic [CODE_BITS-1:0] from);
    logic [CODE_BITS-1:0] pool [8];
    logic [CODE_BITS-1:0] rnd;
    logic [NIB_BITS-1:0]  nib, cand;
    int                   n, roll, step_len;
    rnd  = CODE_BITS'($urandom_range(0, 7));
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      return rnd;
    end
    nib  = map[from*4 +: 4];
    roll = $urandom_range(0, 99);
    step_len = (roll < 15) ? 0 : (roll < 45) ? 1 : (roll < 60) ? 2 :
               (roll < 85) ? 5 : (roll < 95) ? 4 : 3;
    if (step_len == 0) begin
      return from;
    end
    n = 0;
    for (int c = 0; c < 8; c++) begin
      cand = map[c*4 +: 4];
      if (usable(cand) &&
          (!usable(nib) || int'(cand[2:0]) == (int'(nib[2:0]) + step_len) % 6))
      begin
        pool[n] = c[2:0];
        n++;
      end
    end
    if (n == 0) begin
      return rnd;
    end
    return pool[$urandom_range(0, n - 1)];
  endfunction

  // six codes on the six positions, the other two unusable
  function automatic logic [MAP_BITS-1:0] make_map();
    int                  perm [8];
    int                  j, t;
    logic [NIB_BITS-1:0] nib;
    logic [MAP_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      perm[i] = i;
    end
    for (int i = 7; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < 8; i++) begin
      if (i < 6) begin
        nib = {1'b1, i[2:0]};
      end else begin
        t   = $urandom_range(0, 9);
        nib = NIB_BITS'((t < 2) ? 14 + t : t - 2);
      end
      m[perm[i]*4 +: 4] = nib;
    end
    return m;
  endfunction

  // one input transaction, with random gaps ahead of it
  task automatic send_item(input logic [CODE_BITS-1:0] a, input logic [CODE_BITS-1:0] b,
                           input logic typed, input out_item_t report);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= '{hall_a: a, hall_b: b};
    cur_typed  = typed;
    cur_report = report;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // register write once the block has drained
  task automatic write_map(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    // reset defaults: unchanged codes, a forward step, then invalid codes
    stim_tab.push_back(check_row(3'd1, 3'd6, wheel_report(0, 1'b0, 1'b0, 1'b0, 3'd0),
                                 wheel_report(0, 1'b0, 1'b0, 1'b0, 3'd0)));
    stim_tab.push_back(check_row(3'd5, 3'd6, wheel_report(1, 1'b1, 1'b1, 1'b1, 3'd1),
                                 wheel_report(0, 1'b0, 1'b0, 1'b0, 3'd0)));
    stim_tab.push_back(check_row(3'd3, 3'd0, wheel_report(1, 1'b1, 1'b0, 1'b0, 3'd1),
                                 wheel_report(0, 1'b0, 1'b0, 1'b0, 3'd0)));
    // leaving invalid codes, steps of two, one, half turns
    stim_tab.push_back(step_row(3'd5, 3'd4));
    stim_tab.push_back(step_row(3'd6, 3'd5));
    stim_tab.push_back(step_row(3'd2, 3'd6));
    stim_tab.push_back(step_row(3'd7, 3'd2));
    stim_tab.push_back(step_row(3'd5, 3'd5));
    stim_tab.push_back(step_row(3'd5, 3'd5));
    stim_tab.push_back(step_row(3'd0, 3'd4));
    stim_tab.push_back(step_row(3'd7, 3'd7));
    stim_tab.push_back(step_row(3'd0, 3'd0));
    // maps of all ones and all zeros: nothing is usable
    stim_tab.push_back(write_row(REG_WHEEL0_MAP, 32'hFFFF_FFFF));
    stim_tab.push_back(write_row(REG_WHEEL1_MAP, 32'h0000_0000));
    stim_tab.push_back(step_row(3'd1, 3'd1));
    stim_tab.push_back(step_row(3'd2, 3'd3));
    // wheel 0: two codes share a position, one has the valid bit but position six
    stim_tab.push_back(write_row(REG_WHEEL0_MAP, 32'hDCBA_E988));
    stim_tab.push_back(write_row(REG_WHEEL1_MAP, 32'h0FDC_BA98));
    stim_tab.push_back(step_row(3'd0, 3'd0));
    stim_tab.push_back(step_row(3'd1, 3'd1));
    stim_tab.push_back(step_row(3'd3, 3'd6));
    stim_tab.push_back(step_row(3'd7, 3'd7));
    stim_tab.push_back(step_row(3'd2, 3'd5));
    stim_tab.push_back(step_row(3'd4, 3'd3));
    stim_tab.push_back(step_row(3'd6, 3'd1));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_WRITE) begin
        write_map(stim_tab[i].index, stim_tab[i].data);
      end else begin
        send_item(stim_tab[i].hall_a, stim_tab[i].hall_b, stim_tab[i].typed,
                  stim_tab[i].report);
      end
    end

    // random phases, each under its own pair of maps; phase three never idles
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_map(REG_WHEEL0_MAP, MAP0_RESET);
          write_map(REG_WHEEL1_MAP, MAP1_RESET);
        end
        5: begin
          write_map(REG_WHEEL0_MAP, $urandom);
          write_map(REG_WHEEL1_MAP, $urandom);
        end
        default: begin
          write_map(REG_WHEEL0_MAP, make_map());
          write_map(REG_WHEEL1_MAP, make_map());
        end
      endcase
      calm = (phase == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_item(pick_code(map_a, wheel_a.code), pick_code(map_b, wheel_b.code), 1'b0, '0);
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS dual_hall_sensor_step_counter_unit");
    end else begin
      $display("FAIL dual_hall_sensor_step_counter_unit");
    end
    $finish;
  end

endmodule
